FILE: rtl/core/first_fit_heap_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Property shorthands used at the end of the allocator RTL module.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int HEAP_GRANULES_DEF = 4096;
   localparam int HEADER_BYTES_DEF  = 32;
   localparam int GRANULE_BYTES     = 8;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BYTES = 4'd1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO     = 2'd1;
   localparam status_type ST_NO_SPACE = 2'd2;
   localparam status_type ST_BAD_PTR  = 2'd3;

endpackage

FILE: rtl/core/ffa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa request / response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] alloc_bytes;
   logic [63:0] free_addr;

   modport source (output valid, op, alloc_bytes, free_addr, input ready);
   modport sink   (input valid, op, alloc_bytes, free_addr, output ready);
endinterface

interface ffa_rsp_if;
   import ffa_pkg::*;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [63:0] addr;

   modport source (output valid, status, addr, input ready);
   modport sink   (input valid, status, addr, output ready);
endinterface

FILE: rtl/core/ffa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// First-fit heap allocator. Allocate walks the block headers from granule 0 in
// address order; each visited block gets a header RAM read, then a check. A
// grant at a block large enough to split writes the new free tail header,
// then the granted header; otherwise the granted header is written at the check.
// Running off the heap end gives no space, and a zero size request is
// answered without a walk. A free takes a pointer check, header read, next
// and previous neighbor reads where they apply, then the header write-back
// states S_FR_W1 and S_FR_W2. One result item comes back for each request
// item; the next request is taken while a result still waits. After reset,
// and after every write of heap_bytes, a clearing pass over all HEAP_GRANULES
// header entries rebuilds the heap as one free block; no request is taken
// during it. Headers live in two RAMs (head/free/length and predecessor
// link), all read and written through a single sequencer.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator with block split and free-neighbor coalescing.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_unit_defines.svh"
module first_fit_heap_allocator_unit #(
   parameter int HEAP_GRANULES = ffa_pkg::HEAP_GRANULES_DEF,
   parameter int HEADER_BYTES  = ffa_pkg::HEADER_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ffa_req_if.sink                        req_ch,
   ffa_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [ffa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                    csr_wdata
);
   import ffa_pkg::*;

   localparam int AW = $clog2(HEAP_GRANULES);
   localparam int LW = AW + 1;

   // head mark, free flag and length of a block, indexed by head granule
   typedef struct packed {
      logic          head;
      logic          free;
      logic [LW-1:0] len;
   } a_word_type;

   // predecessor link
   typedef struct packed {
      logic          hasp;
      logic [AW-1:0] prev;
   } b_word_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_AL_RD, S_AL_EV, S_AL_SP1, S_AL_SP2,
      S_FR_CHK, S_FR_A, S_FR_N, S_FR_P, S_FR_PE, S_FR_W1, S_FR_W2, S_DONE
   } state_type;

   // effective heap length in granules: round down, clamp to [64, max] bytes
   function automatic logic [LW-1:0] ng_of(input logic [15:0] v);
      logic [19:0] b;
      b = {4'd0, v & 16'hFFF8};
      if (b < 20'd64) b = 20'd64;
      if (b > 20'(HEAP_GRANULES * GRANULE_BYTES)) b = 20'(HEAP_GRANULES * GRANULE_BYTES);
      return LW'(b >> 3);
   endfunction

   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] ng_ff, ng_in;
   logic [63:0]   base_hdr_ff, base_hdr_in;     // heap_base + header size
   logic [14:0]   need_ff, need_in;             // granules needed
   logic [17:0]   total_ff, total_in;           // bytes needed incl. header
   logic [LW-1:0] g_ff, g_in;
   logic [LW-1:0] len_ff, len_in;
   logic          hasp_ff, hasp_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic          nm_ff, nm_in;                 // merged with next block
   logic          pm_ff, pm_in;                 // merged into previous block
   logic [63:0]   off_ff, off_in;
   status_type    res_status_ff, res_status_in;
   logic [63:0]   res_addr_ff, res_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [63:0]   rsp_addr_ff, rsp_addr_in;

   logic          a_we, b_we;
   logic [AW-1:0] a_waddr, b_waddr, raddr;
   a_word_type    a_wdata, a_rd;
   b_word_type    b_wdata, b_rd;

   logic [17:0]   sum;
   logic [LW-1:0] nxt, nb;
   logic [23:0]   len_bytes;

   ffa_ram #(.WIDTH($bits(a_word_type)), .DEPTH(HEAP_GRANULES)) u_hdr_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
      .rd_addr(raddr), .rd_data(a_rd)
   );

   ffa_ram #(.WIDTH($bits(b_word_type)), .DEPTH(HEAP_GRANULES)) u_link_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(raddr), .rd_data(b_rd)
   );

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.addr   = rsp_addr_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ng_in         = ng_ff;
      base_hdr_in   = base_hdr_ff;
      need_in       = need_ff;
      total_in      = total_ff;
      g_in          = g_ff;
      len_in        = len_ff;
      hasp_in       = hasp_ff;
      prev_in       = prev_ff;
      plen_in       = plen_ff;
      nm_in         = nm_ff;
      pm_in         = pm_ff;
      off_in        = off_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      a_we    = 1'b0;
      b_we    = 1'b0;
      a_waddr = AW'(g_ff);
      b_waddr = AW'(g_ff);
      a_wdata = '0;
      b_wdata = '0;
      raddr   = AW'(g_ff);
      sum       = 18'(req_ch.alloc_bytes) + 18'(HEADER_BYTES) + 18'd7;
      nxt       = g_ff + len_ff;
      nb        = g_ff + LW'(need_ff);
      len_bytes = 24'(a_rd.len) << 3;

      case (state_ff)
         S_CLEAR: begin
            a_we    = 1'b1;
            b_we    = 1'b1;
            a_waddr = cnt_ff;
            b_waddr = cnt_ff;
            a_wdata = (cnt_ff == '0) ? '{head: 1'b1, free: 1'b1, len: ng_ff} : '0;
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_ff == AW'(HEAP_GRANULES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.op == OP_ALLOC) begin
                  total_in = sum & ~18'd7;
                  need_in  = sum[17:3];
                  g_in     = '0;
                  if (req_ch.alloc_bytes == 16'd0) begin
                     res_status_in = ST_ZERO;
                     res_addr_in   = '0;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_AL_RD;
                  end
               end else begin
                  off_in   = req_ch.free_addr - base_hdr_ff;
                  state_in = S_FR_CHK;
               end
            end
         end
         S_AL_RD: begin
            if (g_ff >= ng_ff) begin
               res_status_in = ST_NO_SPACE;
               res_addr_in   = '0;
               state_in      = S_DONE;
            end else begin
               state_in = S_AL_EV;
            end
         end
         S_AL_EV: begin
            if (a_rd.len == '0) begin
               res_status_in = ST_NO_SPACE;
               res_addr_in   = '0;
               state_in      = S_DONE;
            end else if (a_rd.free && (24'(a_rd.len) >= 24'(need_ff))) begin
               len_in = a_rd.len;
               if (len_bytes > 24'(total_ff) + 24'(HEADER_BYTES) + 24'd8) begin
                  state_in = S_AL_SP1;
               end else begin
                  a_we          = 1'b1;
                  a_wdata       = '{head: 1'b1, free: 1'b0, len: a_rd.len};
                  res_status_in = ST_OK;
                  res_addr_in   = base_hdr_ff + (64'(g_ff) << 3);
                  state_in      = S_DONE;
               end
            end else begin
               g_in     = g_ff + a_rd.len;
               state_in = S_AL_RD;
            end
         end
         S_AL_SP1: begin
            // tail becomes a new free block after the granted one
            a_we     = 1'b1;
            b_we     = 1'b1;
            a_waddr  = AW'(nb);
            b_waddr  = AW'(nb);
            a_wdata  = '{head: 1'b1, free: 1'b1, len: len_ff - LW'(need_ff)};
            b_wdata  = '{hasp: 1'b1, prev: AW'(g_ff)};
            state_in = S_AL_SP2;
         end
         S_AL_SP2: begin
            a_we    = 1'b1;
            a_wdata = '{head: 1'b1, free: 1'b0, len: LW'(need_ff)};
            if (nxt < ng_ff) begin
               b_we    = 1'b1;
               b_waddr = AW'(nxt);
               b_wdata = '{hasp: 1'b1, prev: AW'(nb)};
            end
            res_status_in = ST_OK;
            res_addr_in   = base_hdr_ff + (64'(g_ff) << 3);
            state_in      = S_DONE;
         end
         S_FR_CHK: begin
            if (off_ff[2:0] != 3'd0 || (off_ff >> 3) >= 64'(ng_ff)) begin
               res_status_in = ST_BAD_PTR;
               res_addr_in   = '0;
               state_in      = S_DONE;
            end else begin
               raddr    = off_ff[AW+2:3];
               g_in     = LW'(off_ff[AW+2:3]);
               state_in = S_FR_A;
            end
         end
         S_FR_A: begin
            nm_in = 1'b0;
            pm_in = 1'b0;
            if (!a_rd.head || a_rd.free) begin
               res_status_in = ST_BAD_PTR;
               res_addr_in   = '0;
               state_in      = S_DONE;
            end else begin
               len_in  = a_rd.len;
               hasp_in = b_rd.hasp;
               prev_in = b_rd.prev;
               raddr   = AW'(g_ff + a_rd.len);
               state_in = (g_ff + a_rd.len < ng_ff) ? S_FR_N : S_FR_P;
            end
         end
         S_FR_N: begin
            if (a_rd.free) begin
               len_in  = len_ff + a_rd.len;
               nm_in   = 1'b1;
               a_we    = 1'b1;
               a_waddr = AW'(nxt);
               a_wdata = '{head: 1'b0, free: 1'b1, len: a_rd.len};
            end
            state_in = S_FR_P;
         end
         S_FR_P: begin
            raddr = prev_ff;
            if (hasp_ff && (LW'(prev_ff) < ng_ff)) begin
               state_in = S_FR_PE;
            end else begin
               state_in = S_FR_W1;
            end
         end
         S_FR_PE: begin
            if (a_rd.free) begin
               pm_in   = 1'b1;
               plen_in = a_rd.len + len_ff;
            end
            state_in = S_FR_W1;
         end
         S_FR_W1: begin
            a_we     = 1'b1;
            a_wdata  = '{head: !pm_ff, free: 1'b1, len: len_ff};
            state_in = S_FR_W2;
         end
         S_FR_W2: begin
            if (pm_ff) begin
               a_we    = 1'b1;
               a_waddr = prev_ff;
               a_wdata = '{head: 1'b1, free: 1'b1, len: plen_ff};
            end
            // block after the merged region points at the survivor
            if ((nm_ff || pm_ff) && nxt < ng_ff) begin
               b_we    = 1'b1;
               b_waddr = AW'(nxt);
               b_wdata = '{hasp: 1'b1, prev: pm_ff ? prev_ff : AW'(g_ff)};
            end
            res_status_in = ST_OK;
            res_addr_in   = '0;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_HEAP_BASE: begin
               base_hdr_in = csr_wdata + 64'(HEADER_BYTES);
            end
            CSR_HEAP_BYTES: begin
               ng_in    = ng_of(csr_wdata[15:0]);
               cnt_in   = '0;
               state_in = S_CLEAR;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         ng_ff        <= ng_of(16'd32768);
         base_hdr_ff  <= 64'(HEADER_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ng_ff        <= ng_in;
         base_hdr_ff  <= base_hdr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      need_ff       <= need_in;
      total_ff      <= total_in;
      g_ff          <= g_in;
      len_ff        <= len_in;
      hasp_ff       <= hasp_in;
      prev_ff       <= prev_in;
      plen_ff       <= plen_in;
      nm_ff         <= nm_in;
      pm_ff         <= pm_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   `FFA_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, req_ch.ready, state_ff != S_CLEAR, "ready in clear")
   `FFA_ASSERT_IMPL(a_walk_in_heap, clock, reset, state_ff == S_AL_EV, g_ff < ng_ff, "walk past heap")
   `FFA_ASSERT_IMPL(a_fail_addr_zero, clock, reset, rsp_ch.valid && rsp_ch.status != ST_OK, rsp_ch.addr == 64'd0, "bad addr")
   `FFA_ASSERT_NEXT(a_done_delivers, clock, reset, state_ff == S_DONE && !rsp_valid_ff && !csr_we, rsp_valid_ff && state_ff == S_IDLE, "no delivery")
endmodule
